// ===== rtl/ahf_pkg.sv =====
// ----------------------------------------------------------------------------
// ahf_pkg
// Shared types, codes and helpers of the ASCII-hex frame response checker.
// ----------------------------------------------------------------------------
package ahf_pkg;

  localparam int POSITION_BITS = 13;
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;

  localparam logic CFG_IDX_START_MARKER = 1'b0;
  localparam logic [7:0] START_MARKER_RESET = 8'h7E;

  localparam logic KIND_INFO   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_BAD_START  = 3'd1,
    ST_RETURN_ERR = 3'd2,
    ST_LENGTH_CHK = 3'd3,
    ST_SHORT      = 3'd4,
    ST_CHECKSUM   = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    EE_NONE      = 2'd0,
    EE_BAD_START = 2'd1,
    EE_RETURN    = 2'd2,
    EE_LENGTH    = 2'd3
  } early_err_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } digit_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  info_byte;
    status_t     status;
    logic [7:0]  return_code;
    logic [11:0] info_length;
  } out_beat_t;

  typedef struct packed {
    logic      valid;
    out_beat_t beat;
  } step_res_t;

  function automatic digit_t digit_of(input logic [7:0] b);
    digit_t d;
    d.ok  = 1'b1;
    d.val = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      d.val = 4'(b - 8'h30);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      d.val = 4'(b - 8'h37);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      d.val = 4'(b - 8'h57);
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

  function automatic logic [7:0] hex_upper(input logic [3:0] n);
    logic [7:0] c;
    if (n < 4'd10) begin
      c = 8'h30 + {4'd0, n};
    end else begin
      c = 8'h37 + {4'd0, n};
    end
    return c;
  endfunction

endpackage

// ===== rtl/ahf_stream_if.sv =====
// ----------------------------------------------------------------------------
// ahf_stream_if
// Valid/ready channels carrying received bytes in and check results out.
// ----------------------------------------------------------------------------
interface ahf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       end_of_frame;

  modport source (output valid, rx_byte, end_of_frame, input ready);
  modport sink (input valid, rx_byte, end_of_frame, output ready);
endinterface

interface ahf_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  info_byte;
  logic [2:0]  status;
  logic [7:0]  return_code;
  logic [11:0] info_length;

  modport source (output valid, kind, info_byte, status, return_code, info_length,
                  input ready);
  modport sink (input valid, kind, info_byte, status, return_code, info_length,
                output ready);
endinterface

// ===== rtl/ahf_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// ahf_cfg_regs
// APB register file holding the frame start marker.
// ----------------------------------------------------------------------------
module ahf_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ahf_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [ahf_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic [ahf_pkg::CFG_DATA_BITS-1:0]  prdata,
  output logic                               pready,
  output logic [7:0]                         start_marker
);
  import ahf_pkg::*;

  logic wr_en;
  logic reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_BITS-1];
  assign wr_en   = psel && penable && pwrite && (reg_idx == CFG_IDX_START_MARKER);

  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker <= START_MARKER_RESET;
    end else if (wr_en) begin
      start_marker <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == CFG_IDX_START_MARKER) begin
      prdata = CFG_DATA_BITS'(start_marker);
    end
  end

endmodule

// ===== rtl/ahf_frame_core.sv =====
// ----------------------------------------------------------------------------
// ahf_frame_core
// Per-frame state and combinational byte step: field parse, sums and status.
// ----------------------------------------------------------------------------
module ahf_frame_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  logic [7:0]         rx_byte,
  input  logic               end_of_frame,
  input  logic [7:0]         start_marker,
  output ahf_pkg::step_res_t res
);
  import ahf_pkg::*;

  localparam logic [POSITION_BITS-1:0] POS_INFO = POSITION_BITS'(13);
  localparam logic [POSITION_BITS-1:0] POS_MAX  = '1;

  logic [POSITION_BITS-1:0] byte_position;
  logic [15:0]              running_sum;
  logic [7:0]               return_value;
  logic                     return_prefix_done;
  logic [7:0]               length_check_char;
  logic [11:0]              length_value;
  logic                     length_prefix_done;
  logic [6:0]               length_digit_sum;
  early_err_t               early_error;
  logic                     checksum_mismatch;

  logic [15:0]              running_sum_next;
  logic [7:0]               return_value_next;
  logic                     return_prefix_done_next;
  logic [7:0]               length_check_char_next;
  logic [11:0]              length_value_next;
  logic                     length_prefix_done_next;
  logic [6:0]               length_digit_sum_next;
  early_err_t               early_error_next;
  logic                     checksum_mismatch_next;

  digit_t                   dg;
  logic [POSITION_BITS-1:0] p;
  logic [POSITION_BITS-1:0] off;
  logic [POSITION_BITS-1:0] lv_ext;
  logic [POSITION_BITS-1:0] ck_k;
  logic                     in_info;
  logic                     in_ck;
  logic [15:0]              ck;
  logic [3:0]               ck_nib;
  logic [6:0]               lc_full;
  status_t                  st;

  always_comb begin
    p       = byte_position;
    dg      = digit_of(rx_byte);
    lv_ext  = POSITION_BITS'(length_value);
    off     = p - POS_INFO;
    in_info = (p >= POS_INFO) && (off < lv_ext);
    ck_k    = off - lv_ext;
    in_ck   = (p >= POS_INFO) && !in_info && (ck_k < POSITION_BITS'(4));
    ck      = 16'd0 - running_sum;
    unique case (ck_k[1:0])
      2'd0:    ck_nib = ck[15:12];
      2'd1:    ck_nib = ck[11:8];
      2'd2:    ck_nib = ck[7:4];
      default: ck_nib = ck[3:0];
    endcase

    running_sum_next        = running_sum;
    return_value_next       = return_value;
    return_prefix_done_next = return_prefix_done;
    length_check_char_next  = length_check_char;
    length_value_next       = length_value;
    length_prefix_done_next = length_prefix_done;
    length_digit_sum_next   = length_digit_sum;
    early_error_next        = early_error;
    checksum_mismatch_next  = checksum_mismatch;
    lc_full                 = 7'd0;

    if (p == '0) begin
      if (rx_byte != start_marker) begin
        early_error_next = EE_BAD_START;
      end
    end else if (p <= POSITION_BITS'(12) || in_info) begin
      running_sum_next = running_sum + {8'd0, rx_byte};
    end

    if (p == POSITION_BITS'(7) || p == POSITION_BITS'(8)) begin
      if (!return_prefix_done && dg.ok) begin
        return_value_next = {return_value[3:0], dg.val};
      end else begin
        return_prefix_done_next = 1'b1;
      end
      if (p == POSITION_BITS'(8) && early_error == EE_NONE) begin
        if ((return_value_next >= 8'h01 && return_value_next <= 8'h06) ||
            return_value_next == 8'h09) begin
          early_error_next = EE_RETURN;
        end
      end
    end else if (p == POSITION_BITS'(9)) begin
      length_check_char_next = rx_byte;
    end else if (p >= POSITION_BITS'(10) && p <= POSITION_BITS'(12)) begin
      if (!length_prefix_done && dg.ok) begin
        length_value_next = {length_value[7:0], dg.val};
      end else begin
        length_prefix_done_next = 1'b1;
      end
      length_digit_sum_next = length_digit_sum + (dg.ok ? {3'd0, dg.val} : 7'h7F);
      if (p == POSITION_BITS'(12) && early_error == EE_NONE) begin
        lc_full = 7'd0 - length_digit_sum_next;
        if (length_check_char != hex_upper(lc_full[3:0])) begin
          early_error_next = EE_LENGTH;
        end
      end
    end else if (in_ck) begin
      if (rx_byte != hex_upper(ck_nib)) begin
        checksum_mismatch_next = 1'b1;
      end
    end

    priority if (p < POSITION_BITS'(12) || early_error_next == EE_BAD_START) begin
      st = ST_BAD_START;
    end else if (early_error_next == EE_RETURN) begin
      st = ST_RETURN_ERR;
    end else if (early_error_next == EE_LENGTH) begin
      st = ST_LENGTH_CHK;
    end else if ({1'b0, p} < (POSITION_BITS+1)'(length_value_next) +
                 (POSITION_BITS+1)'(16)) begin
      st = ST_SHORT;
    end else if (checksum_mismatch_next) begin
      st = ST_CHECKSUM;
    end else begin
      st = ST_OK;
    end

    res = '0;
    if (end_of_frame) begin
      res.valid            = 1'b1;
      res.beat.kind        = KIND_STATUS;
      res.beat.status      = st;
      res.beat.return_code = (st == ST_BAD_START) ? 8'd0 : return_value_next;
      res.beat.info_length = (st == ST_OK) ? length_value_next : 12'd0;
    end else if (in_info && early_error == EE_NONE) begin
      res.valid          = 1'b1;
      res.beat.kind      = KIND_INFO;
      res.beat.info_byte = rx_byte;
    end
    if (!step) begin
      res.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && end_of_frame)) begin
      byte_position      <= '0;
      running_sum        <= '0;
      return_value       <= '0;
      return_prefix_done <= 1'b0;
      length_check_char  <= '0;
      length_value       <= '0;
      length_prefix_done <= 1'b0;
      length_digit_sum   <= '0;
      early_error        <= EE_NONE;
      checksum_mismatch  <= 1'b0;
    end else if (step) begin
      byte_position      <= (p < POS_MAX) ? p + POSITION_BITS'(1) : POS_MAX;
      running_sum        <= running_sum_next;
      return_value       <= return_value_next;
      return_prefix_done <= return_prefix_done_next;
      length_check_char  <= length_check_char_next;
      length_value       <= length_value_next;
      length_prefix_done <= length_prefix_done_next;
      length_digit_sum   <= length_digit_sum_next;
      early_error        <= early_error_next;
      checksum_mismatch  <= checksum_mismatch_next;
    end
  end

endmodule

// ===== rtl/ascii_hex_frame_response_checker_unit.sv =====
// ----------------------------------------------------------------------------
// ascii_hex_frame_response_checker_unit
// Top level: input beat register, frame step core and result register.
// ----------------------------------------------------------------------------
// Takes one received frame byte per beat and can accept a beat every clock
// while the output channel is not stalled. Each byte passes through an input
// register, combinational parse and check logic in the frame core, and a
// result register, which presents the result on the output channel; a stalled
// output holds both registers. Info bytes are forwarded while no early error is
// known; the end-of-frame byte yields one status beat and clears the frame
// state. The start marker is set over APB at byte address 0 and must only be
// written while the unit is idle.
module ascii_hex_frame_response_checker_unit (
  input  logic                               clk,
  input  logic                               rst,
  ahf_in_if.sink                             in_ch,
  ahf_out_if.source                          out_ch,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ahf_pkg::CFG_ADDR_BITS-1:0]  paddr,
  input  logic [ahf_pkg::CFG_DATA_BITS-1:0]  pwdata,
  output logic [ahf_pkg::CFG_DATA_BITS-1:0]  prdata,
  output logic                               pready
);
  import ahf_pkg::*;

  logic [7:0] marker;
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_eof_q;
  logic       advance;
  logic       step;
  logic       in_accept;
  step_res_t  res;
  logic       out_valid;
  out_beat_t  out_beat;

  ahf_cfg_regs u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .start_marker (marker)
  );

  assign advance      = !out_valid || out_ch.ready;
  assign step         = in_valid_q && advance;
  assign in_ch.ready  = !in_valid_q || advance;
  assign in_accept    = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_byte_q <= in_ch.rx_byte;
      in_eof_q  <= in_ch.end_of_frame;
    end
  end

  ahf_frame_core u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .rx_byte      (in_byte_q),
    .end_of_frame (in_eof_q),
    .start_marker (marker),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      out_beat <= res.beat;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.kind        = out_beat.kind;
  assign out_ch.info_byte   = out_beat.info_byte;
  assign out_ch.status      = 3'(out_beat.status);
  assign out_ch.return_code = out_beat.return_code;
  assign out_ch.info_length = out_beat.info_length;

  a_info_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_beat.kind == KIND_INFO) |->
      (out_beat.status == ST_OK && out_beat.return_code == 8'd0 &&
       out_beat.info_length == 12'd0))
    else $error("info beat carries status fields");

  a_bad_start_code: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_beat.kind == KIND_STATUS && out_beat.status == ST_BAD_START) |->
      (out_beat.return_code == 8'd0 && out_beat.info_length == 12'd0))
    else $error("bad start status with nonzero fields");

  a_in_drain: assert property (@(posedge clk) disable iff (rst)
    (step && !in_accept) |=> !in_valid_q)
    else $error("input register not released after step");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_byte_q) && $stable(in_eof_q)))
    else $error("input register lost a pending beat");

endmodule

// ===== tb/ascii_hex_frame_response_checker_unit_test.sv =====
// ----------------------------------------------------------------------------
// ascii_hex_frame_response_checker_unit_test
// Self-checking bench for the ASCII-hex frame response checker.
// ----------------------------------------------------------------------------
// Streams received bytes into the unit and predicts every info and status
// beat with a frame-check model kept in this bench. Each output beat is
// compared field by field with the oldest prediction. The run covers directed
// frames, random well-formed and damaged frames, noise and several start
// markers set over APB. Both channels idle at random.
// ----------------------------------------------------------------------------
module ascii_hex_frame_response_checker_unit_test;
  import ahf_pkg::*;

  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int RANDOM_BEATS     = 800;
  localparam int POS_MAX          = (1 << POSITION_BITS) - 1;
  localparam logic [CFG_ADDR_BITS-1:0] START_MARKER_ADDR =
    CFG_ADDR_BITS'(4 * CFG_IDX_START_MARKER);
  localparam logic [127:0] HEX_DIGITS = "0123456789ABCDEF";

  typedef enum int {
    FL_NONE,
    FL_MARKER,
    FL_LCHK,
    FL_CHECKSUM,
    FL_TRUNC,
    FL_NONHEX,
    FL_LOWER,
    FL_TRAILER
  } frame_flaw_t;

  logic                     clk;
  logic                     rst;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [CFG_ADDR_BITS-1:0] paddr;
  logic [CFG_DATA_BITS-1:0] pwdata;
  logic [CFG_DATA_BITS-1:0] prdata;
  logic                     pready;

  ahf_in_if  in_ch ();
  ahf_out_if out_ch ();

  ascii_hex_frame_response_checker_unit dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predicted frame state
  logic [7:0]               marker_setting;
  logic [POSITION_BITS-1:0] frame_pos;
  logic [15:0]              byte_sum;
  logic [7:0]               rc_value;
  logic                     rc_stopped;
  logic [7:0]               len_check_byte;
  logic [11:0]              lenid_value;
  logic                     lenid_stopped;
  logic [6:0]               lenid_digit_total;
  early_err_t               first_error;
  logic                     checksum_bad;

  out_beat_t  expected_frame_beats[$];
  logic [7:0] frame_bytes[$];
  int         error_count;
  int         beats_sent;
  int         idle_cycles;
  int         ready_hold;
  bit         stall_free;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int hex_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    return -1;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return HEX_DIGITS[8 * (15 - n) +: 8];
  endfunction

  function automatic logic [7:0] lower_hex(input logic [7:0] c);
    return (c >= "A" && c <= "F") ? c + 8'h20 : c;
  endfunction

  function automatic int pick_gap();
    int r;
    if (stall_free) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      error_count++;
    end
  endfunction

  function automatic void clear_frame_state();
    frame_pos         = '0;
    byte_sum          = '0;
    rc_value          = '0;
    rc_stopped        = 1'b0;
    len_check_byte    = '0;
    lenid_value       = '0;
    lenid_stopped     = 1'b0;
    lenid_digit_total = '0;
    first_error       = EE_NONE;
    checksum_bad      = 1'b0;
  endfunction

  function automatic void predict_frame_byte(input logic [7:0] b, input logic eof);
    int         p;
    int         dv;
    int         off;
    int         n_info;
    logic [15:0] ck;
    out_beat_t  r;
    status_t    st;
    p      = frame_pos;
    dv     = hex_value(b);
    n_info = lenid_value;
    if (p == 0) begin
      if (b != marker_setting) first_error = EE_BAD_START;
    end else if (p <= 12 || p - 13 < n_info) begin
      byte_sum = byte_sum + {8'd0, b};
    end
    if (p == 7 || p == 8) begin
      if (!rc_stopped && dv >= 0) rc_value = {rc_value[3:0], 4'(dv)};
      else rc_stopped = 1'b1;
      if (p == 8 && first_error == EE_NONE &&
          ((rc_value >= 8'h01 && rc_value <= 8'h06) || rc_value == 8'h09)) begin
        first_error = EE_RETURN;
      end
    end else if (p == 9) begin
      len_check_byte = b;
    end else if (p >= 10 && p <= 12) begin
      if (!lenid_stopped && dv >= 0) lenid_value = {lenid_value[7:0], 4'(dv)};
      else lenid_stopped = 1'b1;
      lenid_digit_total = lenid_digit_total + ((dv < 0) ? 7'h7F : 7'(dv));
      if (p == 12 && first_error == EE_NONE &&
          len_check_byte != hex_char(4'(7'd0 - lenid_digit_total))) begin
        first_error = EE_LENGTH;
      end
    end else if (p >= 13) begin
      off    = p - 13;
      n_info = lenid_value;
      if (off < n_info) begin
        if (first_error == EE_NONE && !eof) begin
          r           = '0;
          r.kind      = KIND_INFO;
          r.info_byte = b;
          r.status    = ST_OK;
          expected_frame_beats.push_back(r);
        end
      end else if (off - n_info < 4) begin
        ck = 16'h0 - byte_sum;
        if (b != hex_char(4'(ck >> (4 * (3 - (off - n_info)))))) checksum_bad = 1'b1;
      end
    end
    if (eof) begin
      n_info = lenid_value;
      if (p + 1 < 13 || first_error == EE_BAD_START) st = ST_BAD_START;
      else if (first_error == EE_RETURN) st = ST_RETURN_ERR;
      else if (first_error == EE_LENGTH) st = ST_LENGTH_CHK;
      else if (p + 1 < 17 + n_info) st = ST_SHORT;
      else if (checksum_bad) st = ST_CHECKSUM;
      else st = ST_OK;
      r             = '0;
      r.kind        = KIND_STATUS;
      r.status      = st;
      r.return_code = (st == ST_BAD_START) ? 8'h00 : rc_value;
      r.info_length = (st == ST_OK) ? lenid_value : 12'h000;
      expected_frame_beats.push_back(r);
      clear_frame_state();
    end else begin
      frame_pos = (p < POS_MAX) ? POSITION_BITS'(p + 1) : POSITION_BITS'(POS_MAX);
    end
  endfunction

  // build a response frame for the current marker, then damage it as asked
  task automatic build_frame(input logic [7:0] rc, input logic [11:0] lenid,
                             input bit extremes, input frame_flaw_t flaw);
    logic [15:0] chk_sum;
    logic [6:0]  dtotal;
    logic [7:0]  c;
    int          dv;
    int          idx;
    frame_bytes.delete();
    frame_bytes.push_back(marker_setting);
    repeat (6) frame_bytes.push_back(hex_char(4'($urandom_range(0, 15))));
    frame_bytes.push_back(hex_char(rc[7:4]));
    frame_bytes.push_back(hex_char(rc[3:0]));
    frame_bytes.push_back(8'h00);
    frame_bytes.push_back(hex_char(lenid[11:8]));
    frame_bytes.push_back(hex_char(lenid[7:4]));
    frame_bytes.push_back(hex_char(lenid[3:0]));
    if (flaw == FL_LOWER) begin
      for (int i = 1; i <= 12; i++) frame_bytes[i] = lower_hex(frame_bytes[i]);
    end
    if (flaw == FL_NONHEX) begin
      idx = $urandom_range(0, 1) ? $urandom_range(7, 8) : $urandom_range(10, 12);
      do c = 8'($urandom_range(0, 255)); while (hex_value(c) >= 0);
      frame_bytes[idx] = c;
    end
    dtotal = '0;
    for (int i = 10; i <= 12; i++) begin
      dv     = hex_value(frame_bytes[i]);
      dtotal = dtotal + ((dv < 0) ? 7'h7F : 7'(dv));
    end
    frame_bytes[9] = hex_char(4'(7'd0 - dtotal));
    if (flaw == FL_LCHK) frame_bytes[9] ^= 8'($urandom_range(1, 255));
    for (int i = 0; i < lenid; i++) begin
      if (extremes) frame_bytes.push_back(i[0] ? 8'hFF : 8'h00);
      else frame_bytes.push_back(8'($urandom_range(0, 255)));
    end
    chk_sum = '0;
    for (int i = 1; i < frame_bytes.size(); i++) chk_sum = chk_sum + {8'd0, frame_bytes[i]};
    chk_sum = 16'h0 - chk_sum;
    for (int k = 3; k >= 0; k--) frame_bytes.push_back(hex_char(4'(chk_sum >> (4 * k))));
    if (flaw == FL_CHECKSUM) begin
      idx = frame_bytes.size() - 1 - $urandom_range(0, 3);
      frame_bytes[idx] ^= 8'($urandom_range(1, 255));
    end
    if (flaw == FL_TRAILER) begin
      repeat ($urandom_range(1, 3)) frame_bytes.push_back(8'($urandom_range(0, 255)));
    end
    if (flaw == FL_MARKER) frame_bytes[0] ^= 8'($urandom_range(1, 255));
    if (flaw == FL_TRUNC) begin
      idx         = $urandom_range(0, frame_bytes.size() - 2);
      frame_bytes = frame_bytes[0:idx];
    end
  endtask

  task automatic send_beat(input logic [7:0] b, input logic eof);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.rx_byte      <= b;
    in_ch.end_of_frame <= eof;
    do @(posedge clk); while (!in_ch.ready);
    predict_frame_byte(b, eof);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_bytes.size(); i++) begin
      send_beat(frame_bytes[i], i == frame_bytes.size() - 1);
    end
  endtask

  // drop valid and let the pipeline empty out
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_frame_beats.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic read_start_marker();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= START_MARKER_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    check_field("start_marker", {24'd0, marker_setting}, prdata);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_start_marker(input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= START_MARKER_ADDR;
    pwdata  <= {24'd0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    marker_setting = value;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    read_start_marker();
  endtask

  task automatic test_marker_reset_value();
    read_start_marker();
  endtask

  task automatic test_directed_frames();
    build_frame(8'h00, 12'h002, 1'b1, FL_NONE);
    send_frame();
    send_beat(8'hFF, 1'b1);
    // close the frame in the middle of its info field
    build_frame(8'h00, 12'h003, 1'b1, FL_NONE);
    frame_bytes = frame_bytes[0:14];
    send_frame();
  endtask

  task automatic test_random_frames();
    logic [7:0]  markers[4];
    logic [7:0]  rc;
    logic [11:0] lenid;
    frame_flaw_t flaw;
    int          stop_at;
    int          r;
    markers = '{8'h00, 8'hFF, 8'($urandom_range(0, 255)), START_MARKER_RESET};
    for (int phase = 0; phase < 4; phase++) begin
      drain();
      write_start_marker(markers[phase]);
      stop_at = beats_sent + RANDOM_BEATS / 4;
      while (beats_sent < stop_at) begin
        stall_free = ($urandom_range(0, 5) == 0);
        if ($urandom_range(0, 9) < 2) begin
          frame_bytes.delete();
          repeat ($urandom_range(1, 24)) frame_bytes.push_back(8'($urandom_range(0, 255)));
          if ($urandom_range(0, 1)) frame_bytes[0] = marker_setting;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 70) rc = 8'h00;
          else if (r < 85) begin
            rc = 8'($urandom_range(1, 7));
            if (rc == 8'h07) rc = 8'h09;
          end else rc = 8'($urandom_range(0, 255));
          if ($urandom_range(0, 99) < 85) lenid = 12'($urandom_range(0, 12));
          else lenid = 12'($urandom_range(13, 48));
          if ($urandom_range(0, 2) == 0) flaw = FL_NONE;
          else flaw = frame_flaw_t'($urandom_range(0, int'(FL_TRAILER)));
          build_frame(rc, lenid, 1'b0, flaw);
        end
        send_frame();
      end
    end
    stall_free = 1'b0;
  endtask

  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (ready_hold > 0) begin
      out_ch.ready <= 1'b0;
      ready_hold--;
    end else begin
      out_ch.ready <= 1'b1;
      ready_hold = pick_gap();
    end
  end

  always @(posedge clk) begin : check_results
    out_beat_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_frame_beats.size() == 0) begin
        $error("unexpected result beat: kind %0h status %0h", out_ch.kind, out_ch.status);
        error_count++;
      end else begin
        want = expected_frame_beats.pop_front();
        check_field("kind", want.kind, out_ch.kind);
        check_field("info_byte", want.info_byte, out_ch.info_byte);
        check_field("status", want.status, out_ch.status);
        check_field("return_code", want.return_code, out_ch.return_code);
        check_field("info_length", want.info_length, out_ch.info_length);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("ascii_hex_frame_response_checker_unit test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst                = 1'b1;
    in_ch.valid        = 1'b0;
    in_ch.rx_byte      = '0;
    in_ch.end_of_frame = 1'b0;
    out_ch.ready       = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    marker_setting     = START_MARKER_RESET;
    clear_frame_state();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_marker_reset_value();
    test_directed_frames();
    test_random_frames();
    drain();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("ascii_hex_frame_response_checker_unit test passed");
    end else begin
      $display("ascii_hex_frame_response_checker_unit test failed");
    end
    $finish;
  end

endmodule
